FILE: src/esst_pkg.sv
`default_nettype none
package esst_pkg;

	localparam int SLOT_ENTRIES_DEF       = 16;
	localparam int SIGNAL_ENTRIES_DEF     = 16;
	localparam int EVENTS_PER_MESSAGE_DEF = 32;

	localparam int COUNT_W = 5;

	localparam logic [3:0] OP_TICK      = 4'd0;
	localparam logic [3:0] OP_EVENT_RX  = 4'd1;
	localparam logic [3:0] OP_SLOT_REQ  = 4'd2;
	localparam logic [3:0] OP_SIG_REQ   = 4'd3;
	localparam logic [3:0] OP_SLOT_ALL  = 4'd4;
	localparam logic [3:0] OP_SIG_ALL   = 4'd5;
	localparam logic [3:0] OP_SET_IDX   = 4'd6;
	localparam logic [3:0] OP_SET_CH    = 4'd7;
	localparam logic [3:0] OP_LOAD_SLOT = 4'd8;
	localparam logic [3:0] OP_LOAD_SIG  = 4'd9;
	localparam logic [3:0] OP_QUERY_IDX = 4'd10;
	localparam logic [3:0] OP_QUERY_CH  = 4'd11;
	localparam logic [3:0] OP_SEND_NOW  = 4'd12;

	localparam logic [2:0] KIND_ANSWER  = 3'd0;
	localparam logic [2:0] KIND_STATE   = 3'd1;
	localparam logic [2:0] KIND_SLOT_RP = 3'd2;
	localparam logic [2:0] KIND_SIG_RP  = 3'd3;
	localparam logic [2:0] KIND_EVENT   = 3'd4;

	localparam logic REG_SLOT_COUNT = 1'b0;
	localparam logic REG_SIG_COUNT  = 1'b1;

	typedef struct packed {
		logic [3:0]  operation;
		logic [3:0]  entry_index;
		logic [15:0] channel;
		logic [15:0] period_ms;
		logic        state_bit;
		logic        tx_ready;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] out_channel;
		logic [15:0] out_period;
		logic        out_state;
		logic        found;
		logic        message_end;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    push;
		logic    fin;
		result_t res;
	} emit_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_RD,
		S_EV,
		S_ANS,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		P_AGE_SLOT,
		P_AGE_SIG,
		P_REP_SLOT,
		P_REP_SIG,
		P_EVENT,
		P_SEARCH_SLOT,
		P_SEARCH_SIG,
		P_INDEX
	} phase_t;

endpackage
`default_nettype wire

FILE: src/event_slot_signal_table_top.sv
`default_nettype none
// Event slot and signal table. Each item runs through a sequencer that walks
// the table memories one entry at a time, with a read step per entry visited
// and an update step where the entry needs one. A tick ages both tables and,
// if tx_ready is set, then sends the first pending slot report, the first
// pending signal report and the pending events. Loads, bulk requests and
// unknown operations go straight from dispatch to the answer.
// Results pass through a hold register and a one-entry output register; the last
// flag marks the final result of an item. The table memories need no clearing after reset.
module event_slot_signal_table_top #(
	parameter int SLOT_ENTRIES       = esst_pkg::SLOT_ENTRIES_DEF,
	parameter int SIGNAL_ENTRIES     = esst_pkg::SIGNAL_ENTRIES_DEF,
	parameter int EVENTS_PER_MESSAGE = esst_pkg::EVENTS_PER_MESSAGE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire esst_pkg::item_t              item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output esst_pkg::result_t                 result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [esst_pkg::COUNT_W-1:0] cfg_data
);
	esst_pkg::emit_req_t req;
	logic                grant;

	esst_ctrl #(
		.SLOT_ENTRIES(SLOT_ENTRIES),
		.SIGNAL_ENTRIES(SIGNAL_ENTRIES),
		.EVENTS_PER_MESSAGE(EVENTS_PER_MESSAGE)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .grant(grant)
	);

	esst_emit u_emit (
		.clk(clk), .arst_n(arst_n), .req(req), .grant(grant),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);
endmodule
`default_nettype wire

FILE: src/esst_ram.sv
`default_nettype none
module esst_ram #(
	parameter int W = 16,
	parameter int D = 16
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                  wdata,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/esst_emit.sv
`default_nettype none
module esst_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire esst_pkg::emit_req_t req,
	output logic                     grant,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output esst_pkg::result_t        result
);
	// One result is held back so that the last flag can be set once the item is done.
	logic               hv_q;
	esst_pkg::result_t  hold_q;
	logic               out_free;
	logic               load;
	esst_pkg::result_t  load_data;

	assign out_free = !result_valid || result_ready;

	always_comb begin
		grant     = 1'b0;
		load      = 1'b0;
		load_data = hold_q;
		load_data.last = 1'b0;
		if (req.push) begin
			grant = !hv_q || out_free;
			load  = hv_q && out_free;
		end else if (req.fin) begin
			grant = !hv_q || out_free;
			load  = hv_q && out_free;
			load_data.last = 1'b1;
			if (hold_q.kind == esst_pkg::KIND_EVENT) begin
				load_data.message_end = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			if (req.push && grant) begin
				hv_q <= 1'b1;
			end else if (req.fin && grant) begin
				hv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result <= load_data;
		end
		if (req.push && grant) begin
			hold_q <= req.res;
		end
	end
endmodule
`default_nettype wire

FILE: src/esst_ctrl.sv
`default_nettype none
module esst_ctrl #(
	parameter int SLOT_ENTRIES       = esst_pkg::SLOT_ENTRIES_DEF,
	parameter int SIGNAL_ENTRIES     = esst_pkg::SIGNAL_ENTRIES_DEF,
	parameter int EVENTS_PER_MESSAGE = esst_pkg::EVENTS_PER_MESSAGE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire esst_pkg::item_t     item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [esst_pkg::COUNT_W-1:0] cfg_data,
	output esst_pkg::emit_req_t      req,
	input  wire logic                grant
);
	localparam int S    = SLOT_ENTRIES;
	localparam int G    = SIGNAL_ENTRIES;
	localparam int MAXE = (S > G) ? S : G;
	localparam int CW   = $clog2(MAXE + 1);
	localparam int SAW  = (S > 1) ? $clog2(S) : 1;
	localparam int GAW  = (G > 1) ? $clog2(G) : 1;
	localparam int NW   = $clog2(EVENTS_PER_MESSAGE + 1);

	esst_pkg::state_t state_q, state_d;
	esst_pkg::phase_t phase_q, phase_d;
	esst_pkg::item_t  item_q;
	logic [CW-1:0]    i_q, i_d;
	logic [NW-1:0]    cnt_q, cnt_d;
	logic [15:0]      ans_ch_q, ans_ch_d;
	logic             ans_st_q, ans_st_d;
	logic             ans_fnd_q, ans_fnd_d;

	logic [S-1:0] s_act_q, s_act_d, s_rp_q, s_rp_d, s_evld_q, s_evld_d;
	logic [G-1:0] g_act_q, g_act_d, g_rp_q, g_rp_d, g_ev_q, g_ev_d, g_evld_q, g_evld_d;

	logic [esst_pkg::COUNT_W-1:0] slot_count_q, sig_count_q;
	logic [CW-1:0] s_used, g_used, lim;

	logic [SAW-1:0] sa, s_waddr;
	logic [GAW-1:0] ga, g_waddr;
	logic           sram_we, gram_we, sel_we, gel_we;
	logic [31:0]    s_rd, g_rd;
	logic [15:0]    sel_rd, gel_rd, sel_wdata, gel_wdata;

	logic [15:0] e_cur, e_inc, e_new, per_cur, el_rd;
	logic        el_vld, fire;
	logic        mend;

	assign sa = i_q[SAW-1:0];
	assign ga = i_q[GAW-1:0];
	assign cfg_ready = 1'b1;

	assign s_used = (7'(slot_count_q) > 7'(S)) ? CW'(S) : CW'(slot_count_q);
	assign g_used = (7'(sig_count_q) > 7'(G)) ? CW'(G) : CW'(sig_count_q);

	esst_ram #(.W(32), .D(S)) u_slot_tab (
		.clk(clk), .we(sram_we), .waddr(s_waddr),
		.wdata({item_q.channel, item_q.period_ms}), .raddr(sa), .rdata(s_rd)
	);
	esst_ram #(.W(32), .D(G)) u_sig_tab (
		.clk(clk), .we(gram_we), .waddr(g_waddr),
		.wdata({item_q.channel, item_q.period_ms}), .raddr(ga), .rdata(g_rd)
	);
	esst_ram #(.W(16), .D(S)) u_slot_el (
		.clk(clk), .we(sel_we), .waddr(sa), .wdata(sel_wdata), .raddr(sa), .rdata(sel_rd)
	);
	esst_ram #(.W(16), .D(G)) u_sig_el (
		.clk(clk), .we(gel_we), .waddr(ga), .wdata(gel_wdata), .raddr(ga), .rdata(gel_rd)
	);

	// Timer aging shared by both tables.
	always_comb begin
		if (phase_q == esst_pkg::P_AGE_SLOT) begin
			el_rd   = sel_rd;
			el_vld  = s_evld_q[sa];
			per_cur = s_rd[15:0];
		end else begin
			el_rd   = gel_rd;
			el_vld  = g_evld_q[ga];
			per_cur = g_rd[15:0];
		end
		e_cur = el_vld ? el_rd : 16'd0;
		e_inc = (e_cur == 16'hFFFF) ? e_cur : e_cur + 16'd1;
		fire  = e_inc >= per_cur;
		e_new = fire ? 16'd0 : e_inc;
	end

	assign mend = (cnt_q == NW'(EVENTS_PER_MESSAGE - 1));

	always_comb begin
		case (phase_q)
			esst_pkg::P_AGE_SLOT, esst_pkg::P_REP_SLOT, esst_pkg::P_SEARCH_SLOT: lim = s_used;
			default: lim = g_used;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		i_d       = i_q;
		cnt_d     = cnt_q;
		ans_ch_d  = ans_ch_q;
		ans_st_d  = ans_st_q;
		ans_fnd_d = ans_fnd_q;
		s_act_d   = s_act_q;
		s_rp_d    = s_rp_q;
		s_evld_d  = s_evld_q;
		g_act_d   = g_act_q;
		g_rp_d    = g_rp_q;
		g_ev_d    = g_ev_q;
		g_evld_d  = g_evld_q;
		item_ready = 1'b0;
		req       = '0;
		sram_we   = 1'b0;
		gram_we   = 1'b0;
		sel_we    = 1'b0;
		gel_we    = 1'b0;
		sel_wdata = e_new;
		gel_wdata = e_new;
		s_waddr   = sa;
		g_waddr   = ga;

		case (state_q)
			esst_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = esst_pkg::S_DISP;
				end
			end
			esst_pkg::S_DISP: begin
				i_d       = '0;
				ans_ch_d  = item_q.channel;
				ans_st_d  = 1'b0;
				ans_fnd_d = 1'b0;
				state_d   = esst_pkg::S_ANS;
				case (item_q.operation)
					esst_pkg::OP_TICK: begin
						phase_d = esst_pkg::P_AGE_SLOT;
						state_d = esst_pkg::S_RD;
					end
					esst_pkg::OP_EVENT_RX, esst_pkg::OP_SLOT_REQ, esst_pkg::OP_QUERY_CH: begin
						phase_d = esst_pkg::P_SEARCH_SLOT;
						state_d = esst_pkg::S_RD;
					end
					esst_pkg::OP_SIG_REQ, esst_pkg::OP_SET_CH: begin
						phase_d = esst_pkg::P_SEARCH_SIG;
						state_d = esst_pkg::S_RD;
					end
					esst_pkg::OP_SLOT_ALL: begin
						for (int k = 0; k < S; k++) begin
							if (CW'(k) < s_used) begin
								s_rp_d[k] = 1'b1;
							end
						end
						ans_fnd_d = 1'b1;
					end
					esst_pkg::OP_SIG_ALL: begin
						for (int k = 0; k < G; k++) begin
							if (CW'(k) < g_used) begin
								g_rp_d[k] = 1'b1;
							end
						end
						ans_fnd_d = 1'b1;
					end
					esst_pkg::OP_SET_IDX, esst_pkg::OP_SEND_NOW: begin
						if (7'(item_q.entry_index) < 7'(g_used) &&
						    (item_q.tx_ready || item_q.operation == esst_pkg::OP_SET_IDX)) begin
							i_d     = CW'(item_q.entry_index);
							phase_d = esst_pkg::P_INDEX;
							state_d = esst_pkg::S_RD;
						end
					end
					esst_pkg::OP_QUERY_IDX: begin
						if (7'(item_q.entry_index) < 7'(s_used)) begin
							i_d     = CW'(item_q.entry_index);
							phase_d = esst_pkg::P_INDEX;
							state_d = esst_pkg::S_RD;
						end
					end
					esst_pkg::OP_LOAD_SLOT: begin
						s_waddr = SAW'(item_q.entry_index);
						if (7'(item_q.entry_index) < 7'(S)) begin
							sram_we   = 1'b1;
							ans_fnd_d = 1'b1;
						end
					end
					esst_pkg::OP_LOAD_SIG: begin
						g_waddr = GAW'(item_q.entry_index);
						if (7'(item_q.entry_index) < 7'(G)) begin
							gram_we   = 1'b1;
							ans_fnd_d = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			esst_pkg::S_RD: begin
				if (phase_q == esst_pkg::P_INDEX) begin
					state_d = esst_pkg::S_EV;
				end else if (i_q >= lim) begin
					i_d = '0;
					case (phase_q)
						esst_pkg::P_AGE_SLOT: phase_d = esst_pkg::P_AGE_SIG;
						esst_pkg::P_AGE_SIG: begin
							if (item_q.tx_ready) begin
								phase_d = esst_pkg::P_REP_SLOT;
							end else begin
								state_d = esst_pkg::S_FIN;
							end
						end
						esst_pkg::P_REP_SLOT: phase_d = esst_pkg::P_REP_SIG;
						esst_pkg::P_REP_SIG: begin
							phase_d = esst_pkg::P_EVENT;
							cnt_d   = '0;
						end
						esst_pkg::P_EVENT: state_d = esst_pkg::S_FIN;
						default: state_d = esst_pkg::S_ANS;
					endcase
				end else if ((phase_q == esst_pkg::P_REP_SLOT && !s_rp_q[sa]) ||
				             (phase_q == esst_pkg::P_REP_SIG && !g_rp_q[ga]) ||
				             (phase_q == esst_pkg::P_EVENT && !g_ev_q[ga]) ||
				             (phase_q == esst_pkg::P_AGE_SIG && !g_act_q[ga])) begin
					i_d = i_q + CW'(1);
				end else begin
					state_d = esst_pkg::S_EV;
				end
			end
			esst_pkg::S_EV: begin
				case (phase_q)
					esst_pkg::P_AGE_SLOT: begin
						req.res.kind        = esst_pkg::KIND_STATE;
						req.res.out_channel = s_rd[31:16];
						req.res.found       = 1'b1;
						req.push            = fire && s_act_q[sa];
						if (!req.push || grant) begin
							sel_we      = 1'b1;
							s_evld_d[sa] = 1'b1;
							if (fire) begin
								s_act_d[sa] = 1'b0;
							end
							i_d     = i_q + CW'(1);
							state_d = esst_pkg::S_RD;
						end
					end
					esst_pkg::P_AGE_SIG: begin
						gel_we       = 1'b1;
						g_evld_d[ga] = 1'b1;
						if (fire) begin
							g_ev_d[ga] = 1'b1;
						end
						i_d     = i_q + CW'(1);
						state_d = esst_pkg::S_RD;
					end
					esst_pkg::P_REP_SLOT: begin
						req.push            = 1'b1;
						req.res.kind        = esst_pkg::KIND_SLOT_RP;
						req.res.out_channel = s_rd[31:16];
						req.res.out_period  = s_rd[15:0];
						req.res.found       = 1'b1;
						if (grant) begin
							s_rp_d[sa] = 1'b0;
							i_d        = lim;
							state_d    = esst_pkg::S_RD;
						end
					end
					esst_pkg::P_REP_SIG: begin
						req.push            = 1'b1;
						req.res.kind        = esst_pkg::KIND_SIG_RP;
						req.res.out_channel = g_rd[31:16];
						req.res.out_period  = g_rd[15:0];
						req.res.found       = 1'b1;
						if (grant) begin
							g_rp_d[ga] = 1'b0;
							i_d        = lim;
							state_d    = esst_pkg::S_RD;
						end
					end
					esst_pkg::P_EVENT: begin
						req.push            = 1'b1;
						req.res.kind        = esst_pkg::KIND_EVENT;
						req.res.out_channel = g_rd[31:16];
						req.res.found       = 1'b1;
						req.res.message_end = mend;
						if (grant) begin
							g_ev_d[ga] = 1'b0;
							cnt_d      = mend ? '0 : cnt_q + NW'(1);
							i_d        = i_q + CW'(1);
							state_d    = esst_pkg::S_RD;
						end
					end
					esst_pkg::P_SEARCH_SLOT: begin
						if (s_rd[31:16] == item_q.channel) begin
							ans_fnd_d = 1'b1;
							ans_st_d  = s_act_q[sa];
							case (item_q.operation)
								esst_pkg::OP_EVENT_RX: begin
									req.res.kind        = esst_pkg::KIND_STATE;
									req.res.out_channel = s_rd[31:16];
									req.res.out_state   = 1'b1;
									req.res.found       = 1'b1;
									req.push            = !s_act_q[sa];
									ans_st_d            = 1'b0;
									if (!req.push || grant) begin
										sel_wdata    = 16'd0;
										sel_we       = 1'b1;
										s_evld_d[sa] = 1'b1;
										s_act_d[sa]  = 1'b1;
										state_d      = esst_pkg::S_ANS;
									end
								end
								esst_pkg::OP_SLOT_REQ: begin
									s_rp_d[sa] = 1'b1;
									ans_st_d   = 1'b0;
									state_d    = esst_pkg::S_ANS;
								end
								default: state_d = esst_pkg::S_ANS;
							endcase
						end else begin
							i_d     = i_q + CW'(1);
							state_d = esst_pkg::S_RD;
						end
					end
					esst_pkg::P_SEARCH_SIG: begin
						if (g_rd[31:16] == item_q.channel) begin
							ans_fnd_d = 1'b1;
							if (item_q.operation == esst_pkg::OP_SIG_REQ) begin
								g_rp_d[ga] = 1'b1;
							end else begin
								g_act_d[ga] = item_q.state_bit;
							end
							state_d = esst_pkg::S_ANS;
						end else begin
							i_d     = i_q + CW'(1);
							state_d = esst_pkg::S_RD;
						end
					end
					default: begin
						// indexed access, entry already checked
						ans_fnd_d = 1'b1;
						case (item_q.operation)
							esst_pkg::OP_QUERY_IDX: begin
								ans_ch_d = s_rd[31:16];
								ans_st_d = s_act_q[sa];
								state_d  = esst_pkg::S_ANS;
							end
							esst_pkg::OP_SET_IDX: begin
								ans_ch_d    = g_rd[31:16];
								g_act_d[ga] = item_q.state_bit;
								state_d     = esst_pkg::S_ANS;
							end
							default: begin
								req.push            = 1'b1;
								req.res.kind        = esst_pkg::KIND_EVENT;
								req.res.out_channel = g_rd[31:16];
								req.res.found       = 1'b1;
								req.res.message_end = 1'b1;
								ans_ch_d            = g_rd[31:16];
								if (grant) begin
									state_d = esst_pkg::S_ANS;
								end
							end
						endcase
					end
				endcase
			end
			esst_pkg::S_ANS: begin
				req.push            = 1'b1;
				req.res.kind        = esst_pkg::KIND_ANSWER;
				req.res.out_channel = ans_ch_q;
				req.res.out_state   = ans_st_q;
				req.res.found       = ans_fnd_q;
				if (grant) begin
					state_d = esst_pkg::S_FIN;
				end
			end
			esst_pkg::S_FIN: begin
				req.fin = 1'b1;
				if (grant) begin
					state_d = esst_pkg::S_IDLE;
				end
			end
			default: state_d = esst_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= esst_pkg::S_IDLE;
			phase_q      <= esst_pkg::P_AGE_SLOT;
			cnt_q        <= '0;
			s_act_q      <= '0;
			s_rp_q       <= '0;
			s_evld_q     <= '0;
			g_act_q      <= '0;
			g_rp_q       <= '0;
			g_ev_q       <= '0;
			g_evld_q     <= '0;
			slot_count_q <= '0;
			sig_count_q  <= '0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			s_act_q  <= s_act_d;
			s_rp_q   <= s_rp_d;
			s_evld_q <= s_evld_d;
			g_act_q  <= g_act_d;
			g_rp_q   <= g_rp_d;
			g_ev_q   <= g_ev_d;
			g_evld_q <= g_evld_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == esst_pkg::REG_SLOT_COUNT) begin
					slot_count_q <= cfg_data;
				end else begin
					sig_count_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		i_q       <= i_d;
		ans_ch_q  <= ans_ch_d;
		ans_st_q  <= ans_st_d;
		ans_fnd_q <= ans_fnd_d;
	end

`ifndef NO_ASSERTIONS
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esst_pkg::S_FIN && grant) |=> state_q == esst_pkg::S_IDLE)
		else $error("finish did not return to idle");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == esst_pkg::S_IDLE |-> !(req.push || req.fin))
		else $error("emit request while idle");
	a_tick_no_answer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == esst_pkg::S_ANS |-> item_q.operation != esst_pkg::OP_TICK)
		else $error("tick produced an answer");
`endif
endmodule
`default_nettype wire

FILE: sim/event_slot_signal_table_top_tb.sv
`timescale 1ns / 1ps
module event_slot_signal_table_top_tb;

	localparam int DEPTH = 16;
	localparam int PER_MSG = 32;
	localparam logic [3:0] OP_BAD_LO = esst_pkg::OP_SEND_NOW + 4'd1;
	localparam logic [3:0] OP_BAD_HI = 4'hF;
	localparam int DRAIN_CYCLES = 200;

	class table_scoreboard;
		logic [15:0] slot_ch[DEPTH], slot_to[DEPTH], slot_el[DEPTH];
		logic [15:0] sig_ch[DEPTH], sig_iv[DEPTH], sig_el[DEPTH];
		bit slot_act[DEPTH], slot_rep[DEPTH];
		bit sig_act[DEPTH], sig_rep[DEPTH], sig_ev[DEPTH];
		int slot_cnt, sig_cnt;
		esst_pkg::result_t expected_results[$];
		int errors, checked;

		function int slots_used();
			return slot_cnt > DEPTH ? DEPTH : slot_cnt;
		endfunction

		function int sigs_used();
			return sig_cnt > DEPTH ? DEPTH : sig_cnt;
		endfunction

		function void add(logic [2:0] k, logic [15:0] ch, logic [15:0] per, int st, int fnd,
				int mend);
			esst_pkg::result_t r;
			r.kind = k;
			r.out_channel = ch;
			r.out_period = per;
			r.out_state = 1'(st);
			r.found = 1'(fnd);
			r.message_end = 1'(mend);
			r.last = 1'b0;
			expected_results.push_back(r);
		endfunction

		// advance a timer; true when it fires
		function bit age(inout logic [15:0] el, input logic [15:0] per);
			if (el != 16'hFFFF)
				el++;
			if (el >= per) begin
				el = '0;
				return 1;
			end
			return 0;
		endfunction

		function int find_slot(logic [15:0] ch);
			for (int i = 0; i < slots_used(); i++)
				if (slot_ch[i] == ch)
					return i;
			return -1;
		endfunction

		function int find_sig(logic [15:0] ch);
			for (int i = 0; i < sigs_used(); i++)
				if (sig_ch[i] == ch)
					return i;
			return -1;
		endfunction

		function void tick(bit rdy);
			int cnt;
			int last_ev;
			cnt = 0;
			last_ev = -1;
			for (int i = 0; i < slots_used(); i++)
				if (age(slot_el[i], slot_to[i]) && slot_act[i]) begin
					slot_act[i] = 0;
					add(esst_pkg::KIND_STATE, slot_ch[i], '0, 0, 1, 0);
				end
			for (int i = 0; i < sigs_used(); i++)
				if (sig_act[i])
					if (age(sig_el[i], sig_iv[i]))
						sig_ev[i] = 1;
			if (!rdy)
				return;
			for (int i = 0; i < slots_used(); i++)
				if (slot_rep[i]) begin
					slot_rep[i] = 0;
					add(esst_pkg::KIND_SLOT_RP, slot_ch[i], slot_to[i], 0, 1, 0);
					break;
				end
			for (int i = 0; i < sigs_used(); i++)
				if (sig_rep[i]) begin
					sig_rep[i] = 0;
					add(esst_pkg::KIND_SIG_RP, sig_ch[i], sig_iv[i], 0, 1, 0);
					break;
				end
			for (int i = 0; i < sigs_used(); i++)
				if (sig_ev[i]) begin
					sig_ev[i] = 0;
					cnt++;
					last_ev = expected_results.size();
					add(esst_pkg::KIND_EVENT, sig_ch[i], '0, 0, 1, cnt == PER_MSG);
					if (cnt == PER_MSG)
						cnt = 0;
				end
			if (cnt != 0 && last_ev >= 0)
				expected_results[last_ev].message_end = 1'b1;
		endfunction

		function void note_item(esst_pkg::item_t it);
			int start;
			int k;
			int idx;
			start = expected_results.size();
			idx = int'(it.entry_index);
			case (it.operation)
				esst_pkg::OP_TICK: tick(it.tx_ready);
				esst_pkg::OP_EVENT_RX: begin
					k = find_slot(it.channel);
					if (k >= 0) begin
						slot_el[k] = '0;
						if (!slot_act[k]) begin
							slot_act[k] = 1;
							add(esst_pkg::KIND_STATE, slot_ch[k], '0, 1, 1, 0);
						end
					end
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, k >= 0, 0);
				end
				esst_pkg::OP_SLOT_REQ: begin
					k = find_slot(it.channel);
					if (k >= 0)
						slot_rep[k] = 1;
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, k >= 0, 0);
				end
				esst_pkg::OP_SIG_REQ: begin
					k = find_sig(it.channel);
					if (k >= 0)
						sig_rep[k] = 1;
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, k >= 0, 0);
				end
				esst_pkg::OP_SLOT_ALL: begin
					for (int i = 0; i < slots_used(); i++)
						slot_rep[i] = 1;
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 1, 0);
				end
				esst_pkg::OP_SIG_ALL: begin
					for (int i = 0; i < sigs_used(); i++)
						sig_rep[i] = 1;
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 1, 0);
				end
				esst_pkg::OP_SET_IDX: begin
					if (idx < sigs_used()) begin
						sig_act[idx] = it.state_bit;
						add(esst_pkg::KIND_ANSWER, sig_ch[idx], '0, 0, 1, 0);
					end else
						add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 0, 0);
				end
				esst_pkg::OP_SET_CH: begin
					k = find_sig(it.channel);
					if (k >= 0)
						sig_act[k] = it.state_bit;
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, k >= 0, 0);
				end
				esst_pkg::OP_LOAD_SLOT: begin
					slot_ch[idx] = it.channel;
					slot_to[idx] = it.period_ms;
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 1, 0);
				end
				esst_pkg::OP_LOAD_SIG: begin
					sig_ch[idx] = it.channel;
					sig_iv[idx] = it.period_ms;
					add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 1, 0);
				end
				esst_pkg::OP_QUERY_IDX: begin
					if (idx < slots_used())
						add(esst_pkg::KIND_ANSWER, slot_ch[idx], '0, slot_act[idx], 1, 0);
					else
						add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 0, 0);
				end
				esst_pkg::OP_QUERY_CH: begin
					k = find_slot(it.channel);
					add(esst_pkg::KIND_ANSWER, it.channel, '0, k >= 0 ? slot_act[k] : 1'b0,
						k >= 0, 0);
				end
				esst_pkg::OP_SEND_NOW: begin
					if (idx < sigs_used() && it.tx_ready) begin
						add(esst_pkg::KIND_EVENT, sig_ch[idx], '0, 0, 1, 1);
						add(esst_pkg::KIND_ANSWER, sig_ch[idx], '0, 0, 1, 0);
					end else
						add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 0, 0);
				end
				default: add(esst_pkg::KIND_ANSWER, it.channel, '0, 0, 0, 0);
			endcase
			if (expected_results.size() > start)
				expected_results[$].last = 1'b1;
		endfunction

		function void check_result(esst_pkg::result_t got);
			esst_pkg::result_t exp_r;
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: %p", got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			checked++;
			if (got.kind !== exp_r.kind) begin
				$error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
				errors++;
			end
			if (got.out_channel !== exp_r.out_channel) begin
				$error("out_channel: expected %h, got %h", exp_r.out_channel, got.out_channel);
				errors++;
			end
			if (got.out_period !== exp_r.out_period) begin
				$error("out_period: expected %h, got %h", exp_r.out_period, got.out_period);
				errors++;
			end
			if (got.out_state !== exp_r.out_state) begin
				$error("out_state: expected %b, got %b", exp_r.out_state, got.out_state);
				errors++;
			end
			if (got.found !== exp_r.found) begin
				$error("found: expected %b, got %b", exp_r.found, got.found);
				errors++;
			end
			if (got.message_end !== exp_r.message_end) begin
				$error("message_end: expected %b, got %b", exp_r.message_end, got.message_end);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("last: expected %b, got %b", exp_r.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	esst_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	esst_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [esst_pkg::COUNT_W-1:0] cfg_data = '0;

	table_scoreboard sb = new();
	bit gaps_on = 1'b1;
	int items_sent = 0;
	int configs_done = 0;

	event_slot_signal_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_ready <= gaps_on ? ($urandom_range(99) >= 23) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic esst_pkg::item_t make_item(int op, int idx, int ch, int per, int st,
			int rdy);
		esst_pkg::item_t it;
		it.operation = 4'(op);
		it.entry_index = 4'(idx);
		it.channel = 16'(ch);
		it.period_ms = 16'(per);
		it.state_bit = 1'(st);
		it.tx_ready = 1'(rdy);
		return it;
	endfunction

	task automatic send_item(esst_pkg::item_t it);
		if (gaps_on && $urandom_range(99) < 23) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end else
			@(negedge clk);
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_item(it);
		items_sent++;
	endtask

	// drop valid, wait out every expected result and any silent tick work
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= esst_pkg::COUNT_W'(val);
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == esst_pkg::REG_SLOT_COUNT)
			sb.slot_cnt = val;
		else
			sb.sig_cnt = val;
		configs_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_channel();
		case ($urandom_range(5))
			0: return 16'h0100 + 16'($urandom_range(11));
			1: return 16'h0200 + 16'($urandom_range(15));
			2: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
			3: return 16'($urandom);
			default: return 16'h0100 + 16'($urandom_range(15));
		endcase
	endfunction

	function automatic logic [15:0] pick_period();
		return $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(6));
	endfunction

	function automatic esst_pkg::item_t random_item();
		int r;
		logic [3:0] op;
		r = $urandom_range(99);
		if (r < 30)
			op = esst_pkg::OP_TICK;
		else if (r < 48)
			op = esst_pkg::OP_EVENT_RX;
		else if (r < 56)
			op = $urandom_range(1) ? esst_pkg::OP_SET_IDX : esst_pkg::OP_SET_CH;
		else if (r < 60)
			op = 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
		else
			op = 4'($urandom_range(esst_pkg::OP_SLOT_REQ, esst_pkg::OP_SEND_NOW));
		return make_item(op, $urandom_range(15), pick_channel(), pick_period(),
			$urandom_range(3) != 0, $urandom_range(4) != 0);
	endfunction

	task automatic random_phase(int slots, int sigs, int n);
		write_reg(esst_pkg::REG_SLOT_COUNT, slots);
		write_reg(esst_pkg::REG_SIG_COUNT, sigs);
		repeat (n) send_item(random_item());
		drain();
	endtask

	initial begin
		logic [15:0] ch;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_reg(esst_pkg::REG_SLOT_COUNT, 0);
		write_reg(esst_pkg::REG_SIG_COUNT, 0);

		// empty tables: every lookup misses
		send_item(make_item(esst_pkg::OP_TICK, 0, 0, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(OP_BAD_LO, 15, 16'hFFFF, 16'hFFFF, 1, 1));
		send_item(make_item(OP_BAD_HI, 0, 0, 0, 0, 0));
		send_item(make_item(esst_pkg::OP_QUERY_IDX, 0, 16'h1234, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SEND_NOW, 0, 16'h4321, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SET_IDX, 0, 16'h0055, 0, 1, 1));
		// fill both tables so that nothing unwritten is ever read
		for (int i = 0; i < DEPTH; i++) begin
			ch = i == 0 ? 16'h0000 : i == DEPTH - 1 ? 16'hFFFF : 16'h0100 + 16'(i % 10);
			send_item(make_item(esst_pkg::OP_LOAD_SLOT, i, ch,
				i == DEPTH - 1 ? 16'hFFFF : 16'(i % 4), 0, 1));
		end
		for (int i = 0; i < DEPTH; i++) begin
			ch = i == DEPTH - 1 ? 16'hFFFF : 16'h0200 + 16'(i);
			send_item(make_item(esst_pkg::OP_LOAD_SIG, i, ch,
				i == DEPTH - 2 ? 16'hFFFF : 16'(i % 3), 0, 1));
		end
		drain();

		// count above the depth acts as the depth
		write_reg(esst_pkg::REG_SLOT_COUNT, 31);
		write_reg(esst_pkg::REG_SIG_COUNT, 31);
		send_item(make_item(esst_pkg::OP_EVENT_RX, 0, 16'h0101, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_EVENT_RX, 0, 16'h0000, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_EVENT_RX, 0, 16'hFFFF, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_EVENT_RX, 0, 16'h7777, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SET_IDX, 0, 0, 0, 1, 1));
		send_item(make_item(esst_pkg::OP_SET_IDX, 15, 0, 0, 1, 1));
		send_item(make_item(esst_pkg::OP_SET_CH, 0, 16'h0205, 0, 1, 1));
		send_item(make_item(esst_pkg::OP_SET_CH, 0, 16'h7777, 0, 1, 1));
		send_item(make_item(esst_pkg::OP_SLOT_REQ, 0, 16'h0102, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SIG_REQ, 0, 16'h0203, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(esst_pkg::OP_TICK, 0, 0, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SLOT_ALL, 0, 16'h0abc, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SIG_ALL, 0, 16'h0def, 0, 0, 1));
		repeat (3) send_item(make_item(esst_pkg::OP_TICK, 0, 0, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_QUERY_IDX, 3, 0, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_QUERY_CH, 0, 16'h0101, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_QUERY_CH, 0, 16'h7777, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SEND_NOW, 2, 0, 0, 0, 1));
		send_item(make_item(esst_pkg::OP_SEND_NOW, 2, 0, 0, 0, 0));
		drain();

		random_phase(16, 16, 55);
		random_phase(3, 7, 50);
		random_phase(16, 1, 50);
		gaps_on = 1'b0;
		random_phase(31, 31, 55);
		gaps_on = 1'b1;

		if (sb.expected_results.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_results.size());
			sb.errors++;
		end
		$display("Ran %0d items through %0d register writes; %0d results compared.",
			items_sent, configs_done, sb.checked);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
